>>> src/smsc_pkg.sv
`default_nettype none
package smsc_pkg;

  localparam int COORD_BITS    = 31;
  localparam int THR_BITS      = 32;
  localparam int INV_MAX_BITS  = 31;
  localparam int NUM_COORDS    = 8;
  localparam int DIST_BITS     = COORD_BITS + 1;
  localparam int CMP_BITS      = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;
  localparam int SPAN_BITS     = (COORD_BITS > INV_MAX_BITS) ? COORD_BITS : INV_MAX_BITS;
  localparam int COORDS_BITS   = NUM_COORDS * COORD_BITS;
  localparam int IN_DATA_BITS  = ((COORDS_BITS + 7) / 8) * 8;
  localparam int VERDICT_BITS  = 2;
  localparam int OUT_DATA_BITS = ((VERDICT_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    REQ_INV     = 2'd0,
    REQ_DUP     = 2'd1,
    REQ_INV_DUP = 2'd2,
    REQ_BAD     = 2'd3
  } req_type_t;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_INV  = 2'd1,
    VERDICT_BACK = 2'd2,
    VERDICT_FWD  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REG_DUP_GAP      = 3'd0,
    REG_DUP_OVERLAP  = 3'd1,
    REG_DUP_MAX_SIZE = 3'd2,
    REG_DUP_MIN_SIZE = 3'd3,
    REG_INV_MAX_SIZE = 3'd4,
    REG_INV_OVERLAP  = 3'd5,
    REG_INV_GAP      = 3'd6
  } reg_idx_t;

  // order: first a_start, a_end, b_start, b_end, then the same for second
  typedef coord_t [NUM_COORDS-1:0] coords_t;

  typedef struct packed {
    logic signed [THR_BITS-1:0] dup_gap;
    logic signed [THR_BITS-1:0] dup_ovl;
    logic signed [THR_BITS-1:0] dup_span_hi;
    logic signed [THR_BITS-1:0] dup_span_lo;
    logic [INV_MAX_BITS-1:0]    inv_span_max;
    logic signed [THR_BITS-1:0] inv_ovl;
    logic signed [THR_BITS-1:0] inv_gap;
  } thr_t;

endpackage
`default_nettype wire

>>> src/smsc_cfg.sv
`default_nettype none
module smsc_cfg
  import smsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic      [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                          cfg_pready,
  output thr_t                          thr
);

  thr_t     thr_r;
  thr_t     thr_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_BITS-1:2]);
  assign thr        = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      unique case (idx)
        REG_DUP_GAP:      thr_nxt.dup_gap      = cfg_pwdata;
        REG_DUP_OVERLAP:  thr_nxt.dup_ovl      = cfg_pwdata;
        REG_DUP_MAX_SIZE: thr_nxt.dup_span_hi  = cfg_pwdata;
        REG_DUP_MIN_SIZE: thr_nxt.dup_span_lo  = cfg_pwdata;
        REG_INV_MAX_SIZE: thr_nxt.inv_span_max = cfg_pwdata[INV_MAX_BITS-1:0];
        REG_INV_OVERLAP:  thr_nxt.inv_ovl      = cfg_pwdata;
        REG_INV_GAP:      thr_nxt.inv_gap      = cfg_pwdata;
        default:          thr_nxt = thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DUP_GAP:      cfg_prdata = thr_r.dup_gap;
      REG_DUP_OVERLAP:  cfg_prdata = thr_r.dup_ovl;
      REG_DUP_MAX_SIZE: cfg_prdata = thr_r.dup_span_hi;
      REG_DUP_MIN_SIZE: cfg_prdata = thr_r.dup_span_lo;
      REG_INV_MAX_SIZE: cfg_prdata = CFG_DATA_BITS'(thr_r.inv_span_max);
      REG_INV_OVERLAP:  cfg_prdata = thr_r.inv_ovl;
      REG_INV_GAP:      cfg_prdata = thr_r.inv_gap;
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/smsc_core.sv
`default_nettype none
module smsc_core
  import smsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire thr_t                     thr,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  input  wire logic [1:0]               in_tuser,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [OUT_DATA_BITS-1:0] out_tdata,
  output logic                          out_tuser
);

  // signed distance b - a, sign-extended to compare width
  function automatic logic signed [CMP_BITS-1:0] sub_ext(coord_t b, coord_t a);
    logic signed [DIST_BITS-1:0] d;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    return CMP_BITS'(d);
  endfunction

  function automatic logic signed [CMP_BITS-1:0] inner_dist(coord_t xs, coord_t xe,
                                                            coord_t ys, coord_t ye);
    return (xs < ys) ? sub_ext(ys, xe) : sub_ext(xs, ye);
  endfunction

  function automatic logic signed [CMP_BITS-1:0] outer_dist(coord_t xs, coord_t xe,
                                                            coord_t ys, coord_t ye);
    return (xe > ye) ? sub_ext(xe, ys) : sub_ext(ye, xs);
  endfunction

  logic      s1_v_r;
  coords_t   s1_c_r;
  req_type_t s1_req_r;
  logic      s1_adv;
  logic      in_acc;
  logic      out_v_r;
  verdict_t  out_verdict_r;
  logic      out_bad_r;
  verdict_t  verdict_nxt;
  logic      bad_nxt;

  coords_t   c;
  logic signed [CMP_BITS-1:0] dgap, dovl, dmax, dmin, iovl, igap;
  logic signed [CMP_BITS-1:0] in_back, out_back, in_fwd, out_fwd, d1, d2;
  logic [COORD_BITS-1:0] span;
  logic      ord_fwd, ord_idup, win_back, win_fwd, span_ok, inv_ok;
  verdict_t  dup_v;

  assign s1_adv     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready  = !s1_v_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_BITS'(out_verdict_r);
  assign out_tuser  = out_bad_r;

  always_comb begin
    c    = s1_c_r;
    dgap = CMP_BITS'(thr.dup_gap);
    dovl = CMP_BITS'(thr.dup_ovl);
    dmax = CMP_BITS'(thr.dup_span_hi);
    dmin = CMP_BITS'(thr.dup_span_lo);
    iovl = CMP_BITS'(thr.inv_ovl);
    igap = CMP_BITS'(thr.inv_gap);

    ord_fwd  = (c[0] < c[4]) && (c[1] < c[5]) && (c[2] < c[6]) && (c[3] < c[7]);
    ord_idup = (c[0] < c[4]) && (c[1] < c[5]) && (c[2] > c[6]) && (c[3] > c[7]);

    in_back  = inner_dist(c[0], c[1], c[4], c[5]);
    out_back = outer_dist(c[2], c[3], c[6], c[7]);
    in_fwd   = inner_dist(c[2], c[3], c[6], c[7]);
    out_fwd  = outer_dist(c[0], c[1], c[4], c[5]);
    win_back = (in_back < dgap) && (in_back > dovl) && (out_back < dmax) && (out_back > dmin);
    win_fwd  = (in_fwd < dgap) && (in_fwd > dovl) && (out_fwd < dmax) && (out_fwd > dmin);
    dup_v    = win_back ? VERDICT_BACK : (win_fwd ? VERDICT_FWD : VERDICT_NONE);

    span    = (c[7] >= c[0]) ? (c[7] - c[0]) : (c[0] - c[7]);
    span_ok = !(SPAN_BITS'(span) > SPAN_BITS'(thr.inv_span_max));
    d1      = sub_ext(c[4], c[1]);
    d2      = sub_ext(c[6], c[3]);
    inv_ok  = span_ok && ord_fwd && (d1 > iovl) && (d2 > iovl) && (d1 < igap) && (d2 < igap);

    verdict_nxt = VERDICT_NONE;
    bad_nxt     = 1'b0;
    unique case (s1_req_r)
      REQ_INV:     verdict_nxt = inv_ok ? VERDICT_INV : VERDICT_NONE;
      REQ_DUP:     verdict_nxt = ord_fwd ? dup_v : VERDICT_NONE;
      REQ_INV_DUP: verdict_nxt = ord_idup ? dup_v : VERDICT_NONE;
      default:     bad_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_c_r   <= coords_t'(in_tdata[COORDS_BITS-1:0]);
      s1_req_r <= req_type_t'(in_tuser);
    end
    if (s1_adv) begin
      out_verdict_r <= verdict_nxt;
      out_bad_r     <= bad_nxt;
    end
  end

  a_bad_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_bad_r |-> out_verdict_r == VERDICT_NONE)
    else $error("bad type carries a verdict");

  a_bad_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_req_r == REQ_BAD |=> out_v_r && out_bad_r)
    else $error("unknown type not flagged");

  a_inv_verdict_only_for_inv: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_req_r != REQ_INV |=> out_verdict_r != VERDICT_INV)
    else $error("inversion verdict from a copy test");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_c_r) && $stable(s1_req_r))
    else $error("pending request lost");

endmodule
`default_nettype wire

>>> src/split_molecule_sv_classifier_top.sv
// Pipeline: an accepted request is held in the input reg; its verdict is computed from it and held in the result reg.
// Throughput: one request per cycle; both stages advance together when out_tready holds.
// Backpressure stalls the input stage only when the result register is full and not taken.
// Reset: synchronous active-low rst_n clears both valid stages and all thresholds to zero.
`default_nettype none
module split_molecule_sv_classifier_top
  import smsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // first_a_start, first_a_end, first_b_start, first_b_end,
  // second_a_start, second_a_end, second_b_start, second_b_end
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  input  wire logic [1:0]               in_tuser,   // req_type
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [OUT_DATA_BITS-1:0] out_tdata,  // verdict
  output logic                          out_tuser,  // bad_type
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic      [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  thr_t thr;

  smsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  smsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
